/* rtl/rlesd_pkg.sv */
// Shared types and constants for the run-length sprite decoder.
package rlesd_pkg;

    localparam int unsigned MAX_SIDE     = 1024;
    localparam int unsigned HEADER_WORDS = 15;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned COL_W  = 17;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned HCNT_W = 4;

    localparam logic [COL_W-1:0]  COL_MAX      = {COL_W{1'b1}};
    localparam logic [WORD_W-1:0] MAX_SIDE_W   = WORD_W'(MAX_SIDE);
    localparam logic [HCNT_W-1:0] HEADER_LIMIT = HCNT_W'(HEADER_WORDS);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_HEIGHT  = 3'd1,
        PH_ROWCODE = 3'd2,
        PH_BLANK   = 3'd3,
        PH_COUNT   = 3'd4,
        PH_PIX     = 3'd5
    } phase_t;

    typedef struct packed {
        logic             pixel_valid;
        logic [POS_W-1:0] pixel_x;
        logic [POS_W-1:0] pixel_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             overrun;
        logic             image_end;
    } result_t;

endpackage

/* rtl/rle_sprite_rgb565_decoder_top.sv */
// Top level: input word register, record parser and result register.
// Path: a word accepted into the input register passes through the record parser into the result register on m_axis.
// Throughput: one word per cycle unless m_axis stalls; words that produce no result leave nothing on m_axis.
// A stalled result beat holds at most one more word in the input register.
// Reset: synchronous active-low aresetn clears both valid flags and returns the parser
// to the header phase.
module rle_sprite_rgb565_decoder_top
    import rlesd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] word_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [9:0] pixel_x, [19:10] pixel_y, [27:20] red,
                                       // [35:28] green, [43:36] blue, [47:44] zero
    output logic [1:0]  m_axis_tuser,  // [0] pixel_valid, [1] overrun
    output logic        m_axis_tlast   // image_end
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    logic              out_free;
    logic              advance;
    result_t           result;
    logic              result_present;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    rlesd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .word           (in_word_reg),
        .result         (result),
        .result_present (result_present)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_word_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result_present;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg.blue, out_data_reg.green, out_data_reg.red,
                            out_data_reg.pixel_y, out_data_reg.pixel_x};
    assign m_axis_tuser  = {out_data_reg.overrun, out_data_reg.pixel_valid};
    assign m_axis_tlast  = out_data_reg.image_end;

endmodule

/* rtl/rlesd_parser.sv */
// Record parser: phase tracking, row and segment counters, pixel result build.
module rlesd_parser
    import rlesd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [WORD_W-1:0] word,
    output result_t           result,
    output logic              result_present
);

    phase_t              phase_reg,     phase_next;
    logic [HCNT_W-1:0]   hcount_reg,    hcount_next;
    logic [WORD_W-1:0]   width_reg,     width_next;
    logic [WORD_W-1:0]   height_reg,    height_next;
    logic [WORD_W-1:0]   row_reg,       row_next;
    logic [WORD_W-1:0]   segs_reg,      segs_next;
    logic [WORD_W-1:0]   pix_reg,       pix_next;
    logic [COL_W-1:0]    column_reg,    column_next;

    logic [WORD_W-1:0]   row_inc;
    logic                row_done;
    logic [WORD_W-1:0]   segs_dec;
    logic [WORD_W-1:0]   pix_dec;
    logic [COL_W:0]      col_sum;
    logic                oversize;
    logic                oversize_h;
    logic                end_flag;

    assign row_inc    = row_reg + 1'b1;
    assign row_done   = row_inc >= height_reg;
    assign segs_dec   = segs_reg - 1'b1;
    assign pix_dec    = pix_reg - 1'b1;
    assign col_sum    = {1'b0, column_reg} + {{(COL_W + 1 - WORD_W){1'b0}}, word};
    assign oversize   = (width_reg > MAX_SIDE_W) || (height_reg > MAX_SIDE_W);
    assign oversize_h = (width_reg > MAX_SIDE_W) || (word > MAX_SIDE_W);

    always_comb begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        row_next       = row_reg;
        segs_next      = segs_reg;
        pix_next       = pix_reg;
        column_next    = column_reg;
        end_flag       = 1'b0;
        result         = '0;
        result_present = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (hcount_reg < HEADER_LIMIT) begin
                    hcount_next = hcount_reg + 1'b1;
                end else begin
                    width_next = word;
                    phase_next = PH_HEIGHT;
                end
            end
            PH_HEIGHT: begin
                height_next = word;
                row_next    = '0;
                phase_next  = PH_ROWCODE;
                if (word == '0) begin
                    phase_next  = PH_HEADER;
                    hcount_next = '0;
                    end_flag    = 1'b1;
                end
                result.overrun   = oversize_h;
                result.image_end = end_flag;
                result_present   = oversize_h || end_flag;
            end
            PH_ROWCODE: begin
                column_next = '0;
                if (word <= WORD_W'(1)) begin
                    segs_next = '0;
                    pix_next  = width_reg;
                    if (width_reg == '0) begin
                        // empty row closes at once
                        row_next = row_inc;
                        if (row_done) begin
                            phase_next  = PH_HEADER;
                            hcount_next = '0;
                            end_flag    = 1'b1;
                        end else begin
                            phase_next = PH_ROWCODE;
                        end
                    end else begin
                        phase_next = PH_PIX;
                    end
                end else begin
                    segs_next  = word - 1'b1;
                    phase_next = PH_BLANK;
                end
                result.image_end = end_flag;
                result_present   = end_flag;
            end
            PH_BLANK: begin
                column_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
                phase_next  = PH_COUNT;
            end
            PH_COUNT: begin
                pix_next  = word;
                segs_next = segs_dec;
                if (word == '0) begin
                    if (segs_dec == '0) begin
                        row_next = row_inc;
                        if (row_done) begin
                            phase_next  = PH_HEADER;
                            hcount_next = '0;
                            end_flag    = 1'b1;
                        end else begin
                            phase_next = PH_ROWCODE;
                        end
                    end else begin
                        phase_next = PH_BLANK;
                    end
                end else begin
                    phase_next = PH_PIX;
                end
                result.image_end = end_flag;
                result_present   = end_flag;
            end
            PH_PIX: begin
                if (oversize || (column_reg >= {1'b0, width_reg})) begin
                    result.overrun = 1'b1;
                end else begin
                    result.pixel_valid = 1'b1;
                    result.pixel_x     = column_reg[POS_W-1:0];
                    result.pixel_y     = POS_W'(height_reg - 1'b1 - row_reg);
                    result.red         = {word[15:11], 3'b000};
                    result.green       = {word[10:5], 2'b00};
                    result.blue        = {word[4:0], 3'b000};
                end
                if (column_reg != COL_MAX) begin
                    column_next = column_reg + 1'b1;
                end
                pix_next = pix_dec;
                if (pix_dec == '0) begin
                    if (segs_reg == '0) begin
                        row_next = row_inc;
                        if (row_done) begin
                            phase_next  = PH_HEADER;
                            hcount_next = '0;
                            end_flag    = 1'b1;
                        end else begin
                            phase_next = PH_ROWCODE;
                        end
                    end else begin
                        phase_next = PH_BLANK;
                    end
                end
                result.image_end = end_flag;
                result_present   = 1'b1;
            end
            default: begin
                phase_next  = PH_HEADER;
                hcount_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            row_reg    <= '0;
            segs_reg   <= '0;
            pix_reg    <= '0;
            column_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            segs_reg   <= segs_next;
            pix_reg    <= pix_next;
            column_reg <= column_next;
        end
    end

endmodule

/* rtl/rlesd_checker.sv */
// Port-level checker for the sprite decoder, bound to the top level.
module rlesd_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_pix_not_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("pixel beat flagged as overrun");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 48'd0)
        else $error("non-pixel beat carries payload");

    a_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1] || m_axis_tlast)
        else $error("beat with no pixel, no overrun and no end");

endmodule

bind rle_sprite_rgb565_decoder_top rlesd_assert u_rlesd_assert (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
